// ----- src/cpcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcl_pkg
// Shared types and constants of the chassis power current limiter.
// ----------------------------------------------------------------------------
package cpcl_pkg;

   localparam int MAX_MOTORS = 4;
   localparam int CMD_W      = 16;
   localparam int ABS_W      = CMD_W + 1;
   localparam int CFG_W      = 16;
   localparam int BUDGET_W   = 17;
   localparam int SUM_MAX_W  = ABS_W + $clog2(MAX_MOTORS);
   localparam int PROD_W     = 32;
   // scaled quotient is always below the command magnitude, so 15 bits
   localparam int LANE_Q_W   = 15;
   localparam int LANE_LAT   = 1 + LANE_Q_W;
   localparam int BDIV_Q_W   = 32;

   localparam logic [CFG_W-1:0]    MIN_BUFFER = CFG_W'(500);
   localparam logic [BUDGET_W-1:0] BUDGET_MAX = BUDGET_W'(131070);

   localparam int REQ_DATA_W = 2 * CFG_W + MAX_MOTORS * CMD_W;
   localparam int RSP_RAW_W  = MAX_MOTORS * CMD_W + BUDGET_W;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WARN_BUFFER   = 3'd0,
      CSR_WARN_POWER    = 3'd1,
      CSR_POWER_CAP     = 3'd2,
      CSR_BUFFER_CLIMIT = 3'd3,
      CSR_POWER_CLIMIT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] cmd;
      logic [BUDGET_W-1:0]     budget;
      logic [SUM_MAX_W-1:0]    sum;
      logic                    scaled;
   } lane_in_type;

endpackage

// ----- src/cpcl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcl_div
// Pipelined restoring divider, one quotient bit per stage. The upper
// NW-QW numerator bits must be below the divisor.
// ----------------------------------------------------------------------------
module cpcl_div #(
   parameter int NW = 32,
   parameter int DW = 19,
   parameter int QW = 15
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   logic [DW-1:0] rem_ff [QW-1];
   logic [QW-1:0] low_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DW-1:0] rem_p;
      logic [QW-1:0] low_p;
      logic [DW-1:0] den_p;
      logic [QW-1:0] quo_p;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
         assign rem_p = DW'(num >> QW);
         assign low_p = num[QW-1:0];
         assign den_p = den;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[s-1];
         assign low_p = low_ff[s-1];
         assign den_p = den_ff[s-1];
         assign quo_p = quo_ff[s-1];
      end

      assign trial = {rem_p, low_p[QW-1]};
      assign diff  = trial - {1'b0, den_p};
      assign ge    = trial >= {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[s] <= (quo_p << 1) | QW'(ge);
         end
      end

      if (s < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[s] <= ge ? diff[DW-1:0] : trial[DW-1:0];
               low_ff[s] <= low_p << 1;
               den_ff[s] <= den_p;
            end
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

// ----- src/cpcl_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcl_lane
// One motor lane: |cmd| * budget, divide by the command sum, restore sign.
// ----------------------------------------------------------------------------
module cpcl_lane (
   input  logic                            clock,
   input  logic                            adv,
   input  cpcl_pkg::lane_in_type           lane_in,
   output logic signed [cpcl_pkg::CMD_W-1:0] res
);

   localparam int QW = cpcl_pkg::LANE_Q_W;

   logic [cpcl_pkg::ABS_W-1:0]     mag;
   logic [cpcl_pkg::ABS_W+cpcl_pkg::BUDGET_W-1:0] prod_full;
   logic [cpcl_pkg::PROD_W-1:0]    prod_ff;
   logic [cpcl_pkg::SUM_MAX_W-1:0] sum_ff;
   logic signed [cpcl_pkg::CMD_W-1:0] cmd_ff [QW+1];
   logic                           sc_ff  [QW+1];
   logic [QW-1:0]                  quo;
   logic signed [cpcl_pkg::CMD_W-1:0] mag_q;

   assign mag = lane_in.cmd[cpcl_pkg::CMD_W-1]
              ? cpcl_pkg::ABS_W'(-$signed({lane_in.cmd[cpcl_pkg::CMD_W-1], lane_in.cmd}))
              : cpcl_pkg::ABS_W'(lane_in.cmd);

   // full-width product; the value always fits in PROD_W bits
   assign prod_full = mag * lane_in.budget;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_full[cpcl_pkg::PROD_W-1:0];
         sum_ff    <= lane_in.sum;
         cmd_ff[0] <= lane_in.cmd;
         sc_ff[0]  <= lane_in.scaled;
         for (int i = 1; i <= QW; i++) begin
            cmd_ff[i] <= cmd_ff[i-1];
            sc_ff[i]  <= sc_ff[i-1];
         end
      end
   end

   cpcl_div #(
      .NW(cpcl_pkg::PROD_W),
      .DW(cpcl_pkg::SUM_MAX_W),
      .QW(QW)
   ) u_div (
      .clock(clock),
      .adv  (adv),
      .num  (prod_ff),
      .den  (sum_ff),
      .quo  (quo)
   );

   assign mag_q = $signed(cpcl_pkg::CMD_W'(quo));

   always_comb begin
      if (!sc_ff[QW]) begin
         res = cmd_ff[QW];
      end else if (cmd_ff[QW][cpcl_pkg::CMD_W-1]) begin
         res = -mag_q;
      end else begin
         res = mag_q;
      end
   end

endmodule

// ----- src/chassis_power_current_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chassis_power_current_limiter
// Pipeline: input stage, 32-stage budget divider, budget stage, lane
// multiply register and divider, output register. Throughput: one
// transaction per cycle, set by the fully pipelined dividers; the whole
// pipe holds when the response is stalled.
// Reset: synchronous; clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module chassis_power_current_limiter #(
   parameter int NUM_MOTORS = 4
) (
   input  logic clock,
   input  logic reset,
   // power[15:0], energy_buffer[31:16], cmd_0..cmd_3 [95:32]
   input  logic [cpcl_pkg::REQ_DATA_W-1:0] req_tdata,
   // enable[0]
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // out_0..out_3 [63:0], budget[80:64], zero pad
   output logic [cpcl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // scaled[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cpcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpcl_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int CW   = cpcl_pkg::CMD_W;
   localparam int FW   = cpcl_pkg::CFG_W;
   localparam int BW   = cpcl_pkg::BUDGET_W;
   localparam int SW   = cpcl_pkg::SUM_MAX_W;
   localparam int DLAT = cpcl_pkg::BDIV_Q_W;
   localparam int LLAT = cpcl_pkg::LANE_LAT;
   localparam int VLEN = 1 + DLAT + 1 + LLAT;

   logic [FW-1:0] warn_buffer_ff, warn_power_ff, power_cap_ff, bcl_ff, pcl_ff;

   logic adv;
   logic [VLEN-1:0] valid_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_buffer_ff <= FW'(6000);
         warn_power_ff  <= FW'(5000);
         power_cap_ff   <= FW'(8000);
         bcl_ff         <= FW'(16000);
         pcl_ff         <= FW'(20000);
      end else if (csr_valid) begin
         unique case (csr_index)
            cpcl_pkg::CSR_WARN_BUFFER:   warn_buffer_ff <= csr_wdata;
            cpcl_pkg::CSR_WARN_POWER:    warn_power_ff  <= csr_wdata;
            cpcl_pkg::CSR_POWER_CAP:     power_cap_ff   <= csr_wdata;
            cpcl_pkg::CSR_BUFFER_CLIMIT: bcl_ff         <= csr_wdata;
            cpcl_pkg::CSR_POWER_CLIMIT:  pcl_ff         <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   logic [FW-1:0] pw, ebuf, e_min, mul_a, mul_b, den_in;
   logic [BW-1:0] base_in;
   logic          en;
   logic signed [CW-1:0] cmd_in [cpcl_pkg::MAX_MOTORS];
   logic [SW-1:0] sum_in;

   assign en   = req_tuser;
   assign pw   = req_tdata[FW-1:0];
   assign ebuf = req_tdata[2*FW-1:FW];

   for (genvar m = 0; m < cpcl_pkg::MAX_MOTORS; m++) begin : g_cmd
      assign cmd_in[m] = $signed(req_tdata[2*FW + m*CW +: CW]);
   end

   assign e_min = (ebuf > cpcl_pkg::MIN_BUFFER) ? ebuf : cpcl_pkg::MIN_BUFFER;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      den_in  = FW'(1);
      base_in = '0;
      priority if (!en) begin
         base_in = '0;
      end else if (ebuf < warn_buffer_ff) begin
         mul_a  = bcl_ff;
         mul_b  = e_min;
         den_in = warn_buffer_ff;
      end else if (pw > warn_power_ff && pw < power_cap_ff) begin
         mul_a   = pcl_ff;
         mul_b   = power_cap_ff - pw;
         den_in  = power_cap_ff - warn_power_ff;
         base_in = BW'(bcl_ff);
      end else if (pw > warn_power_ff) begin
         base_in = BW'(bcl_ff);
      end else begin
         base_in = BW'(bcl_ff) + BW'(pcl_ff);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         sum_in = sum_in + (cmd_in[m][CW-1] ? SW'(-$signed({cmd_in[m][CW-1], cmd_in[m]}))
                                            : SW'(cmd_in[m]));
      end
   end

   logic [2*FW-1:0] num0_ff;
   logic [FW-1:0]   den0_ff;
   logic [BW-1:0]   base_ff [DLAT+1];
   logic [SW-1:0]   sum_ff  [DLAT+1];
   logic            en_ff   [DLAT+1];
   logic signed [CW-1:0] cmd_ff [DLAT+1][NUM_MOTORS];

   always_ff @(posedge clock) begin
      if (adv) begin
         num0_ff    <= mul_a * mul_b;
         den0_ff    <= den_in;
         base_ff[0] <= base_in;
         sum_ff[0]  <= sum_in;
         en_ff[0]   <= en;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            cmd_ff[0][m] <= cmd_in[m];
         end
         for (int i = 1; i <= DLAT; i++) begin
            base_ff[i] <= base_ff[i-1];
            sum_ff[i]  <= sum_ff[i-1];
            en_ff[i]   <= en_ff[i-1];
            for (int m = 0; m < NUM_MOTORS; m++) begin
               cmd_ff[i][m] <= cmd_ff[i-1][m];
            end
         end
      end
   end

   logic [DLAT-1:0] bquo;

   cpcl_div #(
      .NW(2*FW + 1),
      .DW(FW),
      .QW(DLAT)
   ) u_bdiv (
      .clock(clock),
      .adv  (adv),
      .num  ({1'b0, num0_ff}),
      .den  (den0_ff),
      .quo  (bquo)
   );

   // budget stage
   logic [DLAT:0]  bsum;
   logic [BW-1:0]  budget_in;
   logic           scaled_in;
   logic [BW-1:0]  budget_ff;
   logic           scaled_ff;
   logic [SW-1:0]  sum1_ff;
   logic signed [CW-1:0] cmd1_ff [NUM_MOTORS];

   assign bsum      = (DLAT+1)'(base_ff[DLAT]) + (DLAT+1)'(bquo);
   assign budget_in = (bsum > (DLAT+1)'(cpcl_pkg::BUDGET_MAX)) ? cpcl_pkg::BUDGET_MAX
                                                               : bsum[BW-1:0];
   assign scaled_in = en_ff[DLAT] && (sum_ff[DLAT] > SW'(budget_in));

   always_ff @(posedge clock) begin
      if (adv) begin
         budget_ff <= budget_in;
         scaled_ff <= scaled_in;
         sum1_ff   <= sum_ff[DLAT];
         for (int m = 0; m < NUM_MOTORS; m++) begin
            cmd1_ff[m] <= cmd_ff[DLAT][m];
         end
      end
   end

   // lanes
   logic signed [CW-1:0] lane_res [cpcl_pkg::MAX_MOTORS];

   for (genvar m = 0; m < cpcl_pkg::MAX_MOTORS; m++) begin : g_lane
      if (m < NUM_MOTORS) begin : g_on
         cpcl_pkg::lane_in_type lin;
         assign lin.cmd    = cmd1_ff[m];
         assign lin.budget = budget_ff;
         assign lin.sum    = sum1_ff;
         assign lin.scaled = scaled_ff;
         cpcl_lane u_lane (
            .clock  (clock),
            .adv    (adv),
            .lane_in(lin),
            .res    (lane_res[m])
         );
      end else begin : g_off
         assign lane_res[m] = '0;
      end
   end

   // merge: carry budget and flag alongside the lanes
   logic [BW-1:0] bud_d_ff [LLAT];
   logic          sc_d_ff  [LLAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         bud_d_ff[0] <= budget_ff;
         sc_d_ff[0]  <= scaled_ff;
         for (int i = 1; i < LLAT; i++) begin
            bud_d_ff[i] <= bud_d_ff[i-1];
            sc_d_ff[i]  <= sc_d_ff[i-1];
         end
      end
   end

   logic [cpcl_pkg::RSP_DATA_W-1:0] rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      for (int m = 0; m < cpcl_pkg::MAX_MOTORS; m++) begin
         rsp_data_in[m*CW +: CW] = lane_res[m];
      end
      rsp_data_in[cpcl_pkg::MAX_MOTORS*CW +: BW] = bud_d_ff[LLAT-1];
   end

   logic [cpcl_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_user_ff;
   logic                            rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[VLEN-2:0], req_tvalid};
         rsp_valid_ff <= valid_ff[VLEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= sc_d_ff[LLAT-1];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- dv/chassis_power_current_limiter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chassis_power_current_limiter_tb
// Self-checking bench for the chassis power current limiter: directed and
// random requests under several register settings, with random gaps on both
// streams; every response is checked against a budget/scale predictor.
// ----------------------------------------------------------------------------
module chassis_power_current_limiter_tb;

   localparam int LATENCY = 51;
   localparam int CW      = cpcl_pkg::CMD_W;
   localparam int BW      = cpcl_pkg::BUDGET_W;
   localparam int FW      = cpcl_pkg::CFG_W;

   typedef struct packed {
      logic signed [CW-1:0] m3, m2, m1, m0;
      logic [BW-1:0]        budget;
      logic                 scaled;
   } limit_result_type;

   logic clock = 0;
   logic reset = 1;
   logic [cpcl_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 0, req_tvalid = 0, req_tready;
   logic [cpcl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser, rsp_tvalid, rsp_tready = 0;
   logic csr_valid = 0, csr_ready;
   logic [cpcl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [FW-1:0] csr_wdata = '0;

   logic [FW-1:0] lim_warn_buffer, lim_warn_power, lim_power_cap;
   logic [FW-1:0] lim_buffer_climit, lim_power_climit;

   limit_result_type pending_limits[$];
   int errors = 0;
   int responses = 0;
   int requests = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   chassis_power_current_limiter dut (.*);

   function automatic logic [BW-1:0] current_budget(logic [15:0] pw,
                                                    logic [15:0] buf_e);
      longint b;
      longint e;
      if (buf_e < lim_warn_buffer) begin
         e = (buf_e > cpcl_pkg::MIN_BUFFER) ? buf_e : cpcl_pkg::MIN_BUFFER;
         b = (longint'(lim_buffer_climit) * e) / lim_warn_buffer;
      end else if (pw > lim_warn_power) begin
         if (pw < lim_power_cap)
            b = lim_buffer_climit + (longint'(lim_power_climit)
                * (lim_power_cap - pw)) / (lim_power_cap - lim_warn_power);
         else
            b = lim_buffer_climit;
      end else begin
         b = longint'(lim_buffer_climit) + lim_power_climit;
      end
      if (b > cpcl_pkg::BUDGET_MAX) b = cpcl_pkg::BUDGET_MAX;
      return b[BW-1:0];
   endfunction

   function automatic limit_result_type limit_commands(logic en, logic [15:0] pw,
         logic [15:0] buf_e, logic signed [15:0] c0, logic signed [15:0] c1,
         logic signed [15:0] c2, logic signed [15:0] c3);
      longint cmd[4];
      longint res[4];
      longint sum;
      longint bud;
      limit_result_type r;
      cmd[0] = c0; cmd[1] = c1; cmd[2] = c2; cmd[3] = c3;
      sum = 0;
      bud = 0;
      r.scaled = 0;
      for (int i = 0; i < 4; i++) res[i] = cmd[i];
      if (en) begin
         bud = current_budget(pw, buf_e);
         for (int i = 0; i < 4; i++) sum += (cmd[i] < 0) ? -cmd[i] : cmd[i];
         if (sum > bud) begin
            r.scaled = 1;
            // SV integer division truncates toward zero
            for (int i = 0; i < 4; i++) res[i] = (cmd[i] * bud) / sum;
         end
      end
      r.m0 = res[0][15:0]; r.m1 = res[1][15:0];
      r.m2 = res[2][15:0]; r.m3 = res[3][15:0];
      r.budget = bud[BW-1:0];
      return r;
   endfunction

   task automatic write_reg(cpcl_pkg::csr_index_type idx, logic [FW-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         cpcl_pkg::CSR_WARN_BUFFER:   lim_warn_buffer = val;
         cpcl_pkg::CSR_WARN_POWER:    lim_warn_power = val;
         cpcl_pkg::CSR_POWER_CAP:     lim_power_cap = val;
         cpcl_pkg::CSR_BUFFER_CLIMIT: lim_buffer_climit = val;
         cpcl_pkg::CSR_POWER_CLIMIT:  lim_power_climit = val;
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [15:0] wb, logic [15:0] wp, logic [15:0] pc,
                             logic [15:0] bl, logic [15:0] pl);
      write_reg(cpcl_pkg::CSR_WARN_BUFFER, wb);
      write_reg(cpcl_pkg::CSR_WARN_POWER, wp);
      write_reg(cpcl_pkg::CSR_POWER_CAP, pc);
      write_reg(cpcl_pkg::CSR_BUFFER_CLIMIT, bl);
      write_reg(cpcl_pkg::CSR_POWER_CLIMIT, pl);
   endtask

   // called at a falling edge; leaves the bench at a falling edge
   task automatic send_request(logic en, logic [15:0] pw, logic [15:0] buf_e,
         logic signed [15:0] c0, logic signed [15:0] c1, logic signed [15:0] c2,
         logic signed [15:0] c3);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= en;
      req_tdata <= {c3, c2, c1, c0, buf_e, pw};
      pending_limits.push_back(limit_commands(en, pw, buf_e, c0, c1, c2, c3));
      do @(posedge clock); while (!req_tready);
      requests++;
      @(negedge clock);
   endtask

   // called at a falling edge, right after the last send
   task automatic finish_phase();
      req_tvalid <= 0;
      while (pending_limits.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_cmd();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [15:0] rand_level(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return lo;
         2: return hi;
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic random_burst(int n);
      for (int i = 0; i < n; i++)
         send_request($urandom_range(0, 7) != 0,
                      rand_level(lim_warn_power, lim_power_cap),
                      rand_level(0, lim_warn_buffer),
                      rand_cmd(), rand_cmd(), rand_cmd(), rand_cmd());
      finish_phase();
   endtask

   task automatic test_directed();
      @(negedge clock);
      send_request(0, 16'hffff, 16'h0000, -16'sd32768, 16'sd32767, 16'sd0, -16'sd1);
      send_request(1, 0, 16'hffff, 16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384);
      send_request(1, 0, 16'hffff, 16'sd100, -16'sd200, 16'sd300, -16'sd400);
      send_request(1, 6000, 16'hffff, 16'sd16384, -16'sd16384, 16'sd16384, 16'sd1);
      send_request(1, 5000, 6000, 16'sd12000, 16'sd12000, 16'sd12000, 16'sd12000);
      send_request(1, 8000, 6000, 16'sd9000, -16'sd9000, 16'sd9000, -16'sd9000);
      send_request(1, 16'hffff, 6000, 16'sd9000, 16'sd9000, 16'sd0, 16'sd0);
      send_request(1, 0, 0, 16'sd5000, 16'sd5000, 16'sd5000, 16'sd5000);
      send_request(1, 0, 499, -16'sd3000, 16'sd3000, 16'sd3000, 16'sd3000);
      send_request(1, 0, 5999, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
      // most negative command taken as magnitude 32768
      send_request(1, 0, 16'hffff, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
      send_request(1, 0, 3000, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
      send_request(1, 0, 0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      finish_phase();
   endtask

   task automatic test_saturation();
      // warning level below the minimum buffer drives the scale above one
      set_limits(16'd1, 16'd0, 16'hffff, 16'hffff, 16'hffff);
      @(negedge clock);
      send_request(1, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_request(1, 100, 16'hffff, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd1);
      send_request(1, 16'hffff, 16'hffff, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd1);
      finish_phase();
      // unknown register index must be ignored
      write_reg(cpcl_pkg::csr_index_type'(3'd7), 16'h1234);
      write_reg(cpcl_pkg::csr_index_type'(3'd5), 16'h0000);
      random_burst(40);
   endtask

   task automatic test_settings();
      set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_burst(40);
      set_limits(16'hffff, 16'd2000, 16'd2001, 16'd100, 16'd30000);
      random_burst(60);
      set_limits(16'd12000, 16'd3000, 16'd9000, 16'd8000, 16'd40000);
      random_burst(60);
      set_limits(16'hffff, 16'hfffe, 16'hffff, 16'hffff, 16'hffff);
      random_burst(40);
      set_limits(16'd6000, 16'd5000, 16'd8000, 16'd16000, 16'd20000);
      random_burst(140);
   endtask

   // response side: random stall per transaction, checks in order
   initial begin
      int stall;
      limit_result_type want, got;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         got = {rsp_tdata[63:48], rsp_tdata[47:32], rsp_tdata[31:16],
                rsp_tdata[15:0], rsp_tdata[80:64], rsp_tuser};
         responses++;
         if (pending_limits.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %h", $time, got);
         end else begin
            want = pending_limits.pop_front();
            if (got.m0 !== want.m0)
               $display("%0t: out_0 expected %0d actual %0d", $time, want.m0, got.m0);
            if (got.m1 !== want.m1)
               $display("%0t: out_1 expected %0d actual %0d", $time, want.m1, got.m1);
            if (got.m2 !== want.m2)
               $display("%0t: out_2 expected %0d actual %0d", $time, want.m2, got.m2);
            if (got.m3 !== want.m3)
               $display("%0t: out_3 expected %0d actual %0d", $time, want.m3, got.m3);
            if (got.budget !== want.budget)
               $display("%0t: budget expected %0d actual %0d", $time, want.budget,
                        got.budget);
            if (got.scaled !== want.scaled)
               $display("%0t: scaled expected %0b actual %0b", $time, want.scaled,
                        got.scaled);
            if (got !== want) errors++;
         end
      end
   end

   initial begin
      lim_warn_buffer = 6000; lim_warn_power = 5000; lim_power_cap = 8000;
      lim_buffer_climit = 16000; lim_power_climit = 20000;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_saturation();
      test_settings();
      if (pending_limits.size() != 0) errors++;
      $display("Sent %0d request transactions, checked %0d responses", requests,
               responses);
      $display("across reset defaults, saturating, zero and extreme register sets.");
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/cpcl_pkg.sv
src/cpcl_div.sv
src/cpcl_lane.sv
src/chassis_power_current_limiter.sv
dv/chassis_power_current_limiter_tb.sv
